[sv/bmds_pkg.sv]
// Package for the box-mean image downscaler.
// Shared widths, constants and the controller/datapath command and status types.
// No dependencies.
package bmds_pkg;

    localparam int MaxWidth   = 2048;
    localparam int MaxScale   = 8;
    localparam int MaxHeight  = 4096;
    localparam int ColDepth   = (MaxWidth + 1) / 2;
    localparam int ColAw      = $clog2(ColDepth);
    localparam int PixW       = 32;
    localparam int ChanW      = 8;
    localparam int NumChan    = 4;
    localparam int RowSumW    = 11;  // up to MaxScale * 255
    localparam int AccW       = 14;  // up to MaxScale^2 * 255
    localparam int RemW       = AccW + 1;
    localparam int RamW       = AccW * NumChan;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 13;

    localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
    localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
    localparam logic [CfgIdxW-1:0] RegScale  = 2'd2;

    typedef struct packed {
        logic       load;      // capture pixel, step position counters
        logic       add;       // add pixel into row block sum, read column sum
        logic       acc;       // combine row block sum with column sum
        logic       fin;       // bottom-edge replication, clear row sum
        logic       wr;        // write column sum back
        logic       div_init;  // set up rounding divide
        logic       div_step;  // one quotient bit per lane
        logic [2:0] div_bit;
        logic       emit;      // load output register
        logic       cfg_wr;    // config write, restarts frame for indices 0-2
    } bmds_cmd_t;

    typedef struct packed {
        logic s_one;
        logic block_end;
        logic band_end;
        logic out_free;
    } bmds_stat_t;

endpackage

[sv/bmds_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module bmds_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/bmds_ctrl.sv]
// Controller state machine for the box-mean downscaler.
// Depends on bmds_pkg.
module bmds_ctrl
    import bmds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  bmds_stat_t stat,
    output bmds_cmd_t  cmd
);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StAdd  = 3'd1;
    localparam logic [2:0] StAcc  = 3'd2;
    localparam logic [2:0] StFin  = 3'd3;
    localparam logic [2:0] StWr   = 3'd4;
    localparam logic [2:0] StDivI = 3'd5;
    localparam logic [2:0] StDiv  = 3'd6;
    localparam logic [2:0] StEmit = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] bit_reg, bit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        bit_next      = bit_reg;
        cmd           = '0;
        cmd.div_bit   = bit_reg;
        s_axis_tready = 1'b0;
        cfg_ready     = 1'b0;
        case (state_reg)
            StIdle:
            begin
                if (cfg_valid)
                begin
                    cfg_ready  = 1'b1;
                    cmd.cfg_wr = 1'b1;
                end
                else
                begin
                    s_axis_tready = 1'b1;
                    if (s_axis_tvalid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = stat.s_one ? StEmit : StAdd;
                    end
                end
            end
            StAdd:
            begin
                cmd.add    = 1'b1;
                state_next = stat.block_end ? StAcc : StIdle;
            end
            StAcc:
            begin
                cmd.acc    = 1'b1;
                state_next = StFin;
            end
            StFin:
            begin
                cmd.fin    = 1'b1;
                state_next = stat.band_end ? StDivI : StWr;
            end
            StWr:
            begin
                cmd.wr     = 1'b1;
                state_next = StIdle;
            end
            StDivI:
            begin
                cmd.div_init = 1'b1;
                bit_next     = 3'd7;
                state_next   = StDiv;
            end
            StDiv:
            begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg - 3'd1;
                if (bit_reg == 3'd0)
                begin
                    state_next = StEmit;
                end
            end
            StEmit:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

endmodule

[sv/bmds_dp.sv]
// Datapath for the box-mean downscaler: config, counters, lane sums,
// column-sum RAM, rounding divider, output register.
// Depends on bmds_pkg and bmds_ram.
module bmds_dp
    import bmds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [PixW-1:0]     s_axis_tdata,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  bmds_cmd_t           cmd,
    output bmds_stat_t          stat,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [PixW-1:0]     m_axis_tdata,
    output logic                m_axis_tlast,
    output logic                m_axis_tuser
);

    // config
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    logic [3:0]  scale_reg;
    logic [11:0] w_eff;
    logic [12:0] h_eff;
    logic [3:0]  s_eff;
    logic [7:0]  n_sq;

    // position
    logic [10:0] col_reg;
    logic [11:0] row_reg;
    logic [2:0]  cib_reg, rib_reg, cib_cap_reg, rib_cap_reg;
    logic [ColAw-1:0] oc_reg, oc_cap_reg;
    logic last_col_now, last_row_now, block_end_now, band_end_now;
    logic last_col_reg, last_row_reg, block_end_reg, band_end_reg;
    logic [2:0] rep_col, rep_row;

    // lanes
    logic [PixW-1:0]    pix_reg;
    logic [RowSumW-1:0] rbs_reg [NumChan];
    logic [AccW-1:0]    acc_reg [NumChan];
    logic [RemW-1:0]    rem_reg [NumChan];
    logic [7:0]         quo_reg [NumChan];
    logic [RamW-1:0]    ram_rd, ram_wd;
    logic [RemW-1:0]    div_sub;

    // output
    logic            out_valid_reg;
    logic [PixW-1:0] out_pix_reg;
    logic            out_eor_reg, out_eof_reg;

    always_comb
    begin
        w_eff = width_reg;
        if (width_reg == '0)
            w_eff = 12'd1;
        else if (width_reg > 12'(MaxWidth))
            w_eff = 12'(MaxWidth);
        h_eff = height_reg;
        if (height_reg == '0)
            h_eff = 13'd1;
        else if (height_reg > 13'(MaxHeight))
            h_eff = 13'(MaxHeight);
        s_eff = scale_reg;
        if (scale_reg == '0)
            s_eff = 4'd1;
        else if (scale_reg > 4'(MaxScale))
            s_eff = 4'(MaxScale);
    end

    assign n_sq          = {4'b0, s_eff} * {4'b0, s_eff};
    assign last_col_now  = ({1'b0, col_reg} == w_eff - 12'd1);
    assign last_row_now  = ({1'b0, row_reg} == h_eff - 13'd1);
    assign block_end_now = last_col_now || ({1'b0, cib_reg} == s_eff - 4'd1);
    assign band_end_now  = last_row_now || ({1'b0, rib_reg} == s_eff - 4'd1);
    assign rep_col       = 3'(s_eff - 4'd1 - {1'b0, cib_cap_reg});
    assign rep_row       = 3'(s_eff - 4'd1 - {1'b0, rib_cap_reg});
    assign div_sub       = RemW'({n_sq, 1'b0}) << cmd.div_bit;

    assign stat.s_one     = (s_eff == 4'd1);
    assign stat.block_end = block_end_reg;
    assign stat.band_end  = band_end_reg;
    assign stat.out_free  = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd640;
            height_reg <= 13'd480;
            scale_reg  <= 4'd2;
            col_reg    <= '0;
            row_reg    <= '0;
            cib_reg    <= '0;
            rib_reg    <= '0;
            oc_reg     <= '0;
            for (int c = 0; c < NumChan; c++)
            begin
                rbs_reg[c] <= '0;
            end
        end
        else if (cmd.cfg_wr)
        begin
            if (cfg_index == RegWidth || cfg_index == RegHeight ||
                cfg_index == RegScale)
            begin
                case (cfg_index)
                    RegWidth:  width_reg  <= cfg_data[11:0];
                    RegHeight: height_reg <= cfg_data;
                    RegScale:  scale_reg  <= cfg_data[3:0];
                    default:   scale_reg  <= scale_reg;
                endcase
                col_reg <= '0;
                row_reg <= '0;
                cib_reg <= '0;
                rib_reg <= '0;
                oc_reg  <= '0;
                for (int c = 0; c < NumChan; c++)
                begin
                    rbs_reg[c] <= '0;
                end
            end
        end
        else
        begin
            if (cmd.load)
            begin
                col_reg <= last_col_now ? '0 : col_reg + 11'd1;
                if (last_col_now)
                    row_reg <= last_row_now ? '0 : row_reg + 12'd1;
                if (s_eff != 4'd1)
                begin
                    cib_reg <= block_end_now ? '0 : cib_reg + 3'd1;
                    if (last_col_now)
                    begin
                        rib_reg <= band_end_now ? '0 : rib_reg + 3'd1;
                        oc_reg  <= '0;
                    end
                    else if (block_end_now)
                    begin
                        oc_reg <= oc_reg + ColAw'(1);
                    end
                end
            end
            for (int c = 0; c < NumChan; c++)
            begin
                if (cmd.add)
                    rbs_reg[c] <= rbs_reg[c] + RowSumW'(pix_reg[c*ChanW +: ChanW])
                        + (last_col_reg ?
                           RowSumW'(pix_reg[c*ChanW +: ChanW]) * RowSumW'(rep_col)
                           : '0);
                else if (cmd.fin)
                    rbs_reg[c] <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_reg       <= s_axis_tdata;
            cib_cap_reg   <= cib_reg;
            rib_cap_reg   <= rib_reg;
            oc_cap_reg    <= oc_reg;
            last_col_reg  <= last_col_now;
            last_row_reg  <= last_row_now;
            block_end_reg <= block_end_now;
            band_end_reg  <= band_end_now;
        end
        for (int c = 0; c < NumChan; c++)
        begin
            if (cmd.acc)
                acc_reg[c] <= AccW'(rbs_reg[c]) +
                    ((rib_cap_reg != '0) ? ram_rd[c*AccW +: AccW] : '0);
            else if (cmd.fin && last_row_reg)
                acc_reg[c] <= acc_reg[c] + AccW'(rbs_reg[c]) * AccW'(rep_row);
            if (cmd.div_init)
            begin
                rem_reg[c] <= {acc_reg[c], 1'b0} + RemW'(n_sq);
                quo_reg[c] <= '0;
            end
            else if (cmd.div_step && rem_reg[c] >= div_sub)
            begin
                rem_reg[c]              <= rem_reg[c] - div_sub;
                quo_reg[c][cmd.div_bit] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NumChan; c++)
        begin
            ram_wd[c*AccW +: AccW] = acc_reg[c];
        end
    end

    bmds_ram #(
        .Width (RamW),
        .Depth (ColDepth)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (cmd.wr),
        .wr_addr (oc_cap_reg),
        .wr_data (ram_wd),
        .rd_en   (cmd.add),
        .rd_addr (oc_cap_reg),
        .rd_data (ram_rd)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_pix_reg <= stat.s_one ? pix_reg
                : {quo_reg[3], quo_reg[2], quo_reg[1], quo_reg[0]};
            out_eor_reg <= last_col_reg;
            out_eof_reg <= last_col_reg && last_row_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;
    assign m_axis_tlast  = out_eor_reg;
    assign m_axis_tuser  = out_eof_reg;

endmodule

[sv/box_mean_image_downscaler_top.sv]
// Top level of the box-mean image downscaler.
// Depends on bmds_pkg, bmds_ctrl, bmds_dp (which holds bmds_ram).
//
// Usage:
//   s_axis carries source pixels in raster order, one 32-bit word each,
//   four 8-bit channels. m_axis carries the averaged pixels; tlast marks
//   the last word of an output row, tuser the last word of the frame.
//   Each S-by-S block is averaged per channel, rounding half up; ragged
//   right/bottom edges replicate the last column/row.
//   cfg writes width (0), height (1) or scale (2); any of these restarts
//   the frame position. Write config only while the block is idle.
//   Sequence: a pixel that does not close a block is captured, then added
//   into the row sum; one that closes a block mid-band also goes through
//   column-sum RAM read, combine and write back; one that closes a band is
//   combined, then passes a bit-per-cycle rounding divider (4 channels in
//   parallel) and the output load. With scale 1 a pixel goes straight to
//   the output register. A new pixel is taken only after these steps end.
//   A stalled receiver holds the output word; the next input is still
//   taken and processed, and the block waits only when a new result
//   needs the output register while it is still full.
//   Reset: config returns to 640 x 480, scale 2, position at frame start.
//   The column-sum RAM needs no clearing; each entry is written on the
//   first row of its band before its read data is used.
module box_mean_image_downscaler_top
    import bmds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [PixW-1:0]     s_axis_tdata,   // [31:0] src_pixel
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [PixW-1:0]     m_axis_tdata,   // [31:0] dst_pixel
    output logic                m_axis_tlast,   // end_of_row
    output logic                m_axis_tuser,   // [0] end_of_frame
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    bmds_cmd_t  cmd;
    bmds_stat_t stat;

    bmds_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .stat          (stat),
        .cmd           (cmd)
    );

    bmds_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .stat          (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
